/* hw/rtl/apm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apm_pkg
// shared constants, register map and pattern helpers of the automaton matcher
// ----------------------------------------------------------------------------
package apm_pkg;

  localparam int StateW      = 5;
  localparam int SymW        = 2;
  localparam int PatSlots    = 16;
  localparam int PatIdxW     = 6;
  localparam int DataW       = 32;
  localparam int PaddrW      = 3;
  localparam int MatchStartW = 16;

  localparam int MaxPatternDefault   = 16;
  localparam int AlphabetSizeDefault = 3;
  localparam int PositionBitsDefault = 16;

  localparam logic [StateW-1:0] LengthReset = StateW'(1);

  // register index, taken from paddr[2]
  localparam logic RegPatternSymbols = 1'b0;
  localparam logic RegPatternLength  = 1'b1;

  function automatic logic [SymW-1:0] pat_sym(input logic [DataW-1:0]   syms,
                                              input logic [PatIdxW-1:0] idx);
    logic [SymW-1:0] res;
    res = '0;
    if (idx < PatIdxW'(PatSlots)) begin
      res = syms[{idx[3:0], 1'b0} +: SymW];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/apm_table_builder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// apm_table_builder
// fills the transition memory one entry at a time from the pattern registers
// ----------------------------------------------------------------------------
module apm_table_builder #(
  parameter int MAX_PATTERN   = apm_pkg::MaxPatternDefault,
  parameter int ALPHABET_SIZE = apm_pkg::AlphabetSizeDefault,
  localparam int Depth = (MAX_PATTERN + 1) * ALPHABET_SIZE,
  localparam int AddrW = $clog2(Depth),
  localparam int AlphW = $clog2(ALPHABET_SIZE)
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              start_i,
  input  wire  [apm_pkg::DataW-1:0]        pattern_symbols_i,
  input  wire  [apm_pkg::StateW-1:0]       len_i,
  output logic                             busy_o,
  output logic                             wr_en_o,
  output logic [AddrW-1:0]                 wr_addr_o,
  output logic [apm_pkg::StateW-1:0]       wr_data_o
);

  logic                       busy_q, busy_d;
  logic [apm_pkg::StateW-1:0] s_q, s_d;
  logic [apm_pkg::StateW-1:0] d_q, d_d;
  logic [AlphW-1:0]           x_q, x_d;

  logic [apm_pkg::StateW-1:0] ns_m1;
  logic                       prefix_ok;
  logic                       last_sym_ok;
  logic                       shift_ok;
  logic                       hit;
  logic                       entry_done;
  logic                       last_x;

  // candidate prefix length is s+1-d, checked one shift per cycle
  assign ns_m1 = s_q - d_q;

  always_comb begin
    prefix_ok = 1'b1;
    for (int i = 0; i < apm_pkg::PatSlots; i++) begin
      if ((apm_pkg::StateW'(i) < ns_m1) &&
          (apm_pkg::pat_sym(pattern_symbols_i,
                            apm_pkg::PatIdxW'(i) + apm_pkg::PatIdxW'(d_q)) !=
           apm_pkg::pat_sym(pattern_symbols_i, apm_pkg::PatIdxW'(i)))) begin
        prefix_ok = 1'b0;
      end
    end
  end

  assign last_sym_ok = apm_pkg::pat_sym(pattern_symbols_i, {1'b0, ns_m1}) ==
                       apm_pkg::SymW'(x_q);
  assign shift_ok    = (d_q != '0) || (s_q < len_i);
  assign hit         = prefix_ok && last_sym_ok && shift_ok;
  assign entry_done  = hit || (d_q == s_q);
  assign last_x      = x_q == AlphW'(ALPHABET_SIZE - 1);

  assign busy_o    = busy_q;
  assign wr_en_o   = busy_q && entry_done;
  assign wr_addr_o = AddrW'(int'(s_q) * ALPHABET_SIZE + int'(x_q));
  assign wr_data_o = hit ? ns_m1 + apm_pkg::StateW'(1) : '0;

  always_comb begin
    busy_d = busy_q;
    s_d    = s_q;
    d_d    = d_q;
    x_d    = x_q;
    if (start_i) begin
      busy_d = 1'b1;
      s_d    = '0;
      d_d    = '0;
      x_d    = '0;
    end else if (busy_q) begin
      if (entry_done) begin
        d_d = '0;
        if (last_x) begin
          x_d = '0;
          if (s_q == len_i) begin
            busy_d = 1'b0;
          end else begin
            s_d = s_q + apm_pkg::StateW'(1);
          end
        end else begin
          x_d = x_q + AlphW'(1);
        end
      end else begin
        d_d = d_q + apm_pkg::StateW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      s_q    <= '0;
      d_q    <= '0;
      x_q    <= '0;
    end else begin
      busy_q <= busy_d;
      s_q    <= s_d;
      d_q    <= d_d;
      x_q    <= x_d;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/automaton_pattern_matcher.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// automaton_pattern_matcher
// finite automaton string matcher with a transition table held in memory
// ----------------------------------------------------------------------------
// Text symbols enter on the in channel (valid/ready), one beat per symbol;
// text_start_i clears the automaton state and the text position. Each beat
// gives one result beat on the out channel: found_o, match_start_o and the
// new state automaton_now_o. A result passes the read stage and then the
// result register; the rate is one beat per cycle while out_ready_i is high,
// set by the loop from the memory read data to the next read address.
// The pattern is set through the APB port: 0x0 pattern_symbols, 0x4
// pattern_length. After reset and after every register write the table is
// rebuilt, one candidate shift per cycle; in_ready_o is low while it runs
// and the automaton state returns to zero.
// A stalled receiver holds the output register; one further beat is taken
// into the read stage, then in_ready_o drops until out_ready_i returns.
// ----------------------------------------------------------------------------
module automaton_pattern_matcher #(
  parameter int MAX_PATTERN   = apm_pkg::MaxPatternDefault,
  parameter int ALPHABET_SIZE = apm_pkg::AlphabetSizeDefault,
  parameter int POSITION_BITS = apm_pkg::PositionBitsDefault
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  // apb configuration port
  input  wire                                psel,
  input  wire                                penable,
  input  wire                                pwrite,
  input  wire  [apm_pkg::PaddrW-1:0]         paddr,
  input  wire  [apm_pkg::DataW-1:0]          pwdata,
  output logic [apm_pkg::DataW-1:0]          prdata,
  output logic                               pready,
  // text symbols
  input  wire                                in_valid_i,
  output logic                               in_ready_o,
  input  wire  [apm_pkg::SymW-1:0]           symbol_i,
  input  wire                                text_start_i,
  // results
  output logic                               out_valid_o,
  input  wire                                out_ready_i,
  output logic                               found_o,
  output logic [apm_pkg::MatchStartW-1:0]    match_start_o,
  output logic [apm_pkg::StateW-1:0]         automaton_now_o
);

  localparam int Depth = (MAX_PATTERN + 1) * ALPHABET_SIZE;
  localparam int AddrW = $clog2(Depth);
  localparam int PosW  = POSITION_BITS;

  // configuration
  logic [apm_pkg::DataW-1:0]  pattern_symbols_q;
  logic [apm_pkg::StateW-1:0] pattern_length_q;
  logic                       cfg_wr;
  logic                       cfg_idx;
  logic [apm_pkg::StateW-1:0] len_eff;

  // table builder
  logic                       build_busy;
  logic                       build_wr_en;
  logic [AddrW-1:0]           build_wr_addr;
  logic [apm_pkg::StateW-1:0] build_wr_data;

  // lookup pipeline
  logic [apm_pkg::StateW-1:0] trans_mem_q [Depth];
  logic [apm_pkg::StateW-1:0] rdata_q;
  logic                       s1_valid_q;
  logic                       s1_zero_q;
  logic [PosW-1:0]            s1_pos_q;
  logic [apm_pkg::StateW-1:0] s1_state;
  logic [apm_pkg::StateW-1:0] state_q;
  logic [apm_pkg::StateW-1:0] cur_state;
  logic [apm_pkg::StateW-1:0] base_state;
  logic [AddrW-1:0]           rd_addr;
  logic [PosW-1:0]            pos_q;
  logic [PosW-1:0]            pos_now;
  logic                       accept;
  logic                       adv1;
  logic                       sym_bad;
  logic [PosW:0]              pos_plus;
  logic [PosW:0]              len_ext;
  logic                       found_d;
  logic [apm_pkg::MatchStartW-1:0] match_start_d;

  // --------------------------------------------------------------------------
  // apb registers
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    unique case (cfg_idx)
      apm_pkg::RegPatternSymbols: prdata = pattern_symbols_q;
      apm_pkg::RegPatternLength:  prdata = apm_pkg::DataW'(pattern_length_q);
      default:                    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_symbols_q <= '0;
      pattern_length_q  <= apm_pkg::LengthReset;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        apm_pkg::RegPatternSymbols: pattern_symbols_q <= pwdata;
        apm_pkg::RegPatternLength:  pattern_length_q  <= pwdata[apm_pkg::StateW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pattern_length_q == '0) begin
      len_eff = apm_pkg::StateW'(1);
    end else if ({1'b0, pattern_length_q} > (apm_pkg::StateW + 1)'(MAX_PATTERN)) begin
      len_eff = apm_pkg::StateW'(MAX_PATTERN);
    end else begin
      len_eff = pattern_length_q;
    end
  end

  apm_table_builder #(
    .MAX_PATTERN   (MAX_PATTERN),
    .ALPHABET_SIZE (ALPHABET_SIZE)
  ) u_builder (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (cfg_wr),
    .pattern_symbols_i (pattern_symbols_q),
    .len_i             (len_eff),
    .busy_o            (build_busy),
    .wr_en_o           (build_wr_en),
    .wr_addr_o         (build_wr_addr),
    .wr_data_o         (build_wr_data)
  );

  // --------------------------------------------------------------------------
  // lookup
  // --------------------------------------------------------------------------
  assign adv1       = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !build_busy && (!s1_valid_q || adv1);
  assign accept     = in_valid_i && in_ready_o;

  assign s1_state  = s1_zero_q ? '0 : rdata_q;
  assign cur_state = s1_valid_q ? s1_state : state_q;

  always_comb begin
    base_state = text_start_i ? '0 : cur_state;
    if (base_state > len_eff) begin
      base_state = '0;
    end
  end

  assign sym_bad = {1'b0, symbol_i} >= (apm_pkg::SymW + 1)'(ALPHABET_SIZE);
  assign rd_addr = AddrW'(int'(base_state) * ALPHABET_SIZE + int'(symbol_i));
  assign pos_now = text_start_i ? '0 : pos_q;

  always_ff @(posedge clk_i) begin
    if (build_wr_en) begin
      trans_mem_q[build_wr_addr] <= build_wr_data;
    end
    if (accept) begin
      rdata_q <= trans_mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_zero_q <= sym_bad;
      s1_pos_q  <= pos_now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      state_q    <= '0;
      pos_q      <= '0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
      end else if (adv1) begin
        s1_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        state_q <= '0;
      end else if (adv1) begin
        state_q <= s1_state;
      end
      if (accept) begin
        pos_q <= (pos_now != '1) ? pos_now + PosW'(1) : pos_now;
      end
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  assign pos_plus = {1'b0, s1_pos_q} + (PosW + 1)'(1);
  assign len_ext  = (PosW + 1)'(len_eff);
  assign found_d  = s1_state == len_eff;

  always_comb begin
    match_start_d = '0;
    if (found_d && (pos_plus >= len_ext)) begin
      match_start_d = apm_pkg::MatchStartW'(pos_plus - len_ext);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      found_o         <= found_d;
      match_start_o   <= match_start_d;
      automaton_now_o <= s1_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv1) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

endmodule
`default_nettype wire

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the automaton pattern matcher: patterns are loaded
// over the apb port while the block is idle, text symbols are streamed with
// random gaps and output stalls, and every result beat is compared with a
// local model of the automaton, its transition table and the text position
// ----------------------------------------------------------------------------
module testbench;

  localparam int Alphabet   = apm_pkg::AlphabetSizeDefault;
  localparam int MaxPattern = apm_pkg::MaxPatternDefault;
  localparam int PosMax     = (1 << apm_pkg::PositionBitsDefault) - 1;
  localparam int TableDepth = (MaxPattern + 1) * Alphabet;
  localparam int IdleLimit  = 4000;
  localparam int RandomItems = 1320;

  typedef struct packed {
    logic                              found;
    logic [apm_pkg::MatchStartW-1:0]   start_pos;
    logic [apm_pkg::StateW-1:0]        prefix;
  } match_beat_t;

  logic                          clk_i;
  logic                          rst_ni       = 1'b0;
  logic                          psel         = 1'b0;
  logic                          penable      = 1'b0;
  logic                          pwrite       = 1'b0;
  logic [apm_pkg::PaddrW-1:0]    paddr        = '0;
  logic [apm_pkg::DataW-1:0]     pwdata       = '0;
  logic [apm_pkg::DataW-1:0]     prdata;
  logic                          pready;
  logic                          in_valid_i   = 1'b0;
  logic                          in_ready_o;
  logic [apm_pkg::SymW-1:0]      symbol_i     = '0;
  logic                          text_start_i = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i  = 1'b0;
  logic                          found_o;
  logic [apm_pkg::MatchStartW-1:0] match_start_o;
  logic [apm_pkg::StateW-1:0]    automaton_now_o;

  // model of the block
  logic [31:0]                   cfg_syms;
  logic [4:0]                    cfg_len;
  logic [4:0]                    transitions [0:TableDepth-1];
  int                            prefix_len;
  logic [15:0]                   text_pos;

  match_beat_t                   expected_beats [$];
  match_beat_t                   want;
  int                            mismatches = 0;
  int                            idle_cycles = 0;
  int                            max_gap;
  int                            max_stall;

  automaton_pattern_matcher u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .symbol_i        (symbol_i),
    .text_start_i    (text_start_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .found_o         (found_o),
    .match_start_o   (match_start_o),
    .automaton_now_o (automaton_now_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int sym_at(input int k);
    if (k >= 16) begin
      return 0;
    end
    return int'(cfg_syms[2*k +: 2]);
  endfunction

  function automatic int effective_len();
    int l;
    l = int'(cfg_len);
    if (l < 1) l = 1;
    if (l > MaxPattern) l = MaxPattern;
    return l;
  endfunction

  // longest pattern prefix that ends the matched prefix s extended by x
  function automatic int next_prefix(input int len, input int s, input int x);
    int  ns;
    int  i;
    bit  ok;
    if (s < len && sym_at(s) == x) begin
      return s + 1;
    end
    for (ns = s; ns > 0; ns--) begin
      if (sym_at(ns - 1) != x) continue;
      ok = 1'b1;
      for (i = 0; i + 1 < ns; i++) begin
        if (sym_at(i) != sym_at(s - (ns - 1) + i)) begin
          ok = 1'b0;
          break;
        end
      end
      if (ok) return ns;
    end
    return 0;
  endfunction

  function automatic void build_transitions();
    int len;
    len = effective_len();
    for (int n = 0; n < TableDepth; n++) transitions[n] = '0;
    for (int s = 0; s <= len; s++) begin
      for (int x = 0; x < Alphabet; x++) begin
        transitions[s*Alphabet + x] = 5'(next_prefix(len, s, x));
      end
    end
    prefix_len = 0;
  endfunction

  function automatic match_beat_t advance_automaton(input logic [1:0] sym,
                                                    input logic       start);
    int          len;
    int          q;
    int          pos;
    match_beat_t r;
    len = effective_len();
    if (start) begin
      prefix_len = 0;
      text_pos   = '0;
    end
    pos = int'(text_pos);
    if (prefix_len > len) prefix_len = 0;
    if (int'(sym) < Alphabet) q = int'(transitions[prefix_len*Alphabet + int'(sym)]);
    else q = 0;
    prefix_len  = q;
    r.found     = (q == len);
    r.start_pos = (r.found && pos + 1 >= len) ? 16'(pos + 1 - len) : '0;
    r.prefix    = 5'(q);
    if (pos < PosMax) text_pos = 16'(pos + 1);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input match_beat_t exp_beat);
    if (mismatches < 10) begin
      $display("%0t %s: expected found=%0b start=%0d state=%0d, got found=%0b start=%0d state=%0d",
               $realtime, what, exp_beat.found, exp_beat.start_pos, exp_beat.prefix,
               found_o, match_start_o, automaton_now_o);
    end
    mismatches++;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_beats.size() == 0) begin
        report_mismatch("unexpected beat", '0);
      end else begin
        want = expected_beats.pop_front();
        if (found_o !== want.found || match_start_o !== want.start_pos ||
            automaton_now_o !== want.prefix) begin
          report_mismatch("result mismatch", want);
        end
      end
    end
  end

  // output side stalls
  initial begin
    int stall;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = $urandom_range(max_stall, 0);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!(out_valid_o && out_ready_i));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
          (psel && penable)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  task automatic send_symbol(input logic [1:0] sym, input logic start);
    int gap;
    gap = $urandom_range(max_gap, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    symbol_i     <= sym;
    text_start_i <= start;
    do @(posedge clk_i); while (!in_ready_o);
    expected_beats.push_back(advance_automaton(sym, start));
  endtask

  // drop valid and wait until every result beat has come out
  task automatic settle();
    in_valid_i <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(input logic reg_sel, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (reg_sel == apm_pkg::RegPatternSymbols) cfg_syms = value;
    else cfg_len = value[4:0];
    build_transitions();
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_pattern(input logic [31:0] syms, input logic [4:0] len);
    settle();
    apb_write(apm_pkg::RegPatternSymbols, syms);
    apb_write(apm_pkg::RegPatternLength, 32'(len));
  endtask

  // reset pattern is a single symbol 0
  task automatic test_reset_pattern();
    send_symbol(2'd0, 1'b1);
    send_symbol(2'd1, 1'b0);
    send_symbol(2'd2, 1'b0);
    send_symbol(2'd0, 1'b0);
  endtask

  // pattern a b a b c: overlapping partial match, then a symbol outside the alphabet
  task automatic test_overlap();
    load_pattern(32'h0000_0244, 5'd5);
    send_symbol(2'd0, 1'b1);
    send_symbol(2'd1, 1'b0);
    send_symbol(2'd0, 1'b0);
    send_symbol(2'd1, 1'b0);
    send_symbol(2'd0, 1'b0);
    send_symbol(2'd1, 1'b0);
    send_symbol(2'd2, 1'b0);
    send_symbol(2'd3, 1'b0);
  endtask

  // length zero acts as one, length above the maximum acts as the maximum
  task automatic test_length_limits();
    load_pattern(32'h9862_4189, 5'd0);
    send_symbol(2'd1, 1'b1);
    send_symbol(2'd2, 1'b0);
    load_pattern(32'h9862_4189, 5'd31);
    for (int k = 0; k < 16; k++) send_symbol(cfg_syms[2*k +: 2], k == 0);
  endtask

  // no gaps and no stalls, one beat per cycle on both sides
  task automatic test_back_to_back();
    max_gap   = 0;
    max_stall = 0;
    load_pattern(32'h0000_0004, 5'd2);
    send_symbol(2'd0, 1'b1);
    for (int n = 0; n < 40; n++) send_symbol(2'($urandom_range(2, 0)), 1'b0);
    send_symbol(2'd0, 1'b0);
    send_symbol(2'd1, 1'b0);
    send_symbol(2'd0, 1'b0);
    send_symbol(2'd1, 1'b0);
  endtask

  // random patterns with texts built mostly from whole and partial occurrences
  task automatic test_random_text();
    int          sent;
    int          phase_items;
    int          n;
    int          pick;
    int          len;
    int          span;
    logic [31:0] syms;
    logic [4:0]  plen;
    sent = 0;
    while (sent < RandomItems) begin
      max_gap   = ($urandom_range(2, 0) == 0) ? 0 : 4;
      max_stall = ($urandom_range(2, 0) == 0) ? 0 : 4;
      syms = $urandom();
      if ($urandom_range(3, 0) != 0) begin
        for (int k = 0; k < 16; k++) begin
          if (syms[2*k +: 2] == 2'd3) syms[2*k +: 2] = 2'($urandom_range(2, 0));
        end
      end
      pick = $urandom_range(9, 0);
      if (pick < 7) plen = 5'($urandom_range(6, 1));
      else if (pick < 9) plen = 5'($urandom_range(16, 7));
      else plen = 5'($urandom_range(31, 0));
      load_pattern(syms, plen);
      len = effective_len();
      phase_items = $urandom_range(120, 40);
      n = 0;
      while (n < phase_items) begin
        pick = $urandom_range(9, 0);
        if (pick < 5) span = len;
        else if (pick < 7) span = (len > 1) ? $urandom_range(len - 1, 1) : 1;
        else span = $urandom_range(4, 1);
        for (int k = 0; k < span; k++) begin
          send_symbol((pick < 7) ? 2'(sym_at(k)) : 2'($urandom_range(3, 0)),
                      $urandom_range(49, 0) == 0);
        end
        n += span;
      end
      sent += n;
    end
  endtask

  initial begin
    max_gap     = 4;
    max_stall   = 4;
    cfg_syms    = '0;
    cfg_len     = apm_pkg::LengthReset;
    text_pos    = '0;
    build_transitions();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_pattern();
    test_overlap();
    test_length_limits();
    test_random_text();
    test_back_to_back();
    settle();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/apm_pkg.sv
hw/rtl/apm_table_builder.sv
hw/rtl/automaton_pattern_matcher.sv
tb/testbench.sv
